[rtl/sjsc_pkg.sv]
// sjsc_pkg: shared constants for the joint smoothing check
// no dependencies
package sjsc_pkg;
  localparam int unsigned DistW = 32;
  localparam logic [DistW-1:0] DistMax = '1;
  localparam int unsigned Axes = 3;
endpackage

[rtl/sjsc_if.sv]
// sjsc_if: valid/ready channel interfaces for points, results and threshold
// no dependencies
interface sjsc_in_if #(parameter int unsigned CW = 32);
  logic valid;
  logic ready;
  logic signed [CW-1:0] prev_start_x, prev_start_y, prev_start_z;
  logic signed [CW-1:0] prev_end_x, prev_end_y, prev_end_z;
  logic signed [CW-1:0] cur_end_x, cur_end_y, cur_end_z;
  modport source (output valid, prev_start_x, prev_start_y, prev_start_z,
                  prev_end_x, prev_end_y, prev_end_z, cur_end_x, cur_end_y,
                  cur_end_z, input ready);
  modport sink (input valid, prev_start_x, prev_start_y, prev_start_z,
                prev_end_x, prev_end_y, prev_end_z, cur_end_x, cur_end_y,
                cur_end_z, output ready);
endinterface

interface sjsc_out_if #(parameter int unsigned CW = 32);
  logic valid;
  logic ready;
  logic [31:0] distance;
  logic adjust;
  logic degenerate;
  logic signed [CW-1:0] mid_x, mid_y, mid_z;
  modport source (output valid, distance, adjust, degenerate, mid_x, mid_y, mid_z,
                  input ready);
  modport sink (input valid, distance, adjust, degenerate, mid_x, mid_y, mid_z,
                output ready);
endinterface

interface sjsc_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/sjsc_front.sv]
// sjsc_front: six stage front end, segment vectors, squared norms, dot product
// and the squared dot product that feeds the divider chain; uses sjsc_pkg
module sjsc_front import sjsc_pkg::*; #(
  parameter int unsigned CW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][CW-1:0]  s_i,
  input  logic [2:0][CW-1:0]  p_i,
  input  logic [2:0][CW-1:0]  e_i,
  output logic                valid_o,
  output logic [4*CW+7:0]     num_o,
  output logic [2*CW+3:0]     den_o,
  output logic [5*CW+4:0]     pass_o
);
  localparam int unsigned AW   = CW + 1;
  localparam int unsigned SUMW = 2 * AW + 2;
  localparam int unsigned HW   = SUMW / 2;
  localparam int unsigned NUMW = 2 * SUMW;
  localparam int unsigned SDW  = 1 + Axes * CW;
  localparam int unsigned PW   = SUMW + SDW;

  logic [5:0] v_q;

  // stage 1: differences, midpoints, degenerate line
  logic signed [AW-1:0] ab_d [Axes], ac_d [Axes], ab_q [Axes], ac_q [Axes];
  logic [Axes-1:0][CW-1:0] mid_d;
  logic [SDW-1:0] side1_q, side2_q;
  logic signed [AW-1:0] sx, px, ex, sum;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      sx = $signed(s_i[i]);
      px = $signed(p_i[i]);
      ex = $signed(e_i[i]);
      ab_d[i] = sx - ex;
      ac_d[i] = px - ex;
      sum = sx + ex;
      mid_d[i] = sum[AW-1:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q <= ab_d;
      ac_q <= ac_d;
      side1_q <= {(p_i == e_i), mid_d};
    end
  end

  // stage 2: per axis products
  logic signed [2*AW-1:0] pab_q [Axes], pac_q [Axes], pdt_q [Axes];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < Axes; i++) begin
        pab_q[i] <= ab_q[i] * ab_q[i];
        pac_q[i] <= ac_q[i] * ac_q[i];
        pdt_q[i] <= ab_q[i] * ac_q[i];
      end
      side2_q <= side1_q;
    end
  end

  // stage 3: sums over the axes
  logic [SUMW-1:0] abab_d, acac_d, acac_q;
  logic signed [SUMW-1:0] dot_d, dot_q, dt;
  logic [PW-1:0] pass3_q, pass4_q, pass5_q, pass6_q;
  always_comb begin
    abab_d = '0;
    acac_d = '0;
    dot_d  = '0;
    for (int i = 0; i < Axes; i++) begin
      dt = pdt_q[i];
      abab_d = abab_d + {2'b00, pab_q[i]};
      acac_d = acac_d + {2'b00, pac_q[i]};
      dot_d  = dot_d + dt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acac_q  <= acac_d;
      dot_q   <= dot_d;
      pass3_q <= {abab_d, side2_q};
    end
  end

  // stage 4: dot magnitude, divisor forced to one on a degenerate line
  logic deg3;
  logic [SUMW-1:0] dmag_q, den4_q, den5_q, den6_q;
  assign deg3 = pass3_q[SDW-1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q  <= deg3 ? '0 : (dot_q[SUMW-1] ? SUMW'(-dot_q) : SUMW'(dot_q));
      den4_q  <= deg3 ? SUMW'(1) : acac_q;
      pass4_q <= pass3_q;
    end
  end

  // stage 5: partial products of the squared dot product
  logic [SUMW-1:0] hh_q, hl_q, ll_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q    <= dmag_q[SUMW-1:HW] * dmag_q[SUMW-1:HW];
      hl_q    <= dmag_q[SUMW-1:HW] * dmag_q[HW-1:0];
      ll_q    <= dmag_q[HW-1:0] * dmag_q[HW-1:0];
      den5_q  <= den4_q;
      pass5_q <= pass4_q;
    end
  end

  // stage 6: combine partials into the dividend
  logic [NUMW-1:0] num_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= {hh_q, ll_q} + (NUMW'(hl_q) << (HW + 1));
      den6_q  <= den5_q;
      pass6_q <= pass5_q;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  assign valid_o = v_q[5];
  assign num_o   = num_q;
  assign den_o   = den6_q;
  assign pass_o  = pass6_q;
endmodule

[rtl/sjsc_div_cell.sv]
// sjsc_div_cell: one restoring division cell, one quotient bit per cycle while en_i is high
// uses sjsc_pkg
module sjsc_div_cell import sjsc_pkg::*; #(
  parameter int unsigned DW = 68,
  parameter int unsigned PW = 165
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] quo_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pass_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] num_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] den_o,
  output logic [PW-1:0] pass_o
);
  logic [DW:0] trial, diff;
  logic ge;

  // trial subtract of the divisor
  always_comb begin
    trial = {rem_i, num_i[DW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = ~diff[DW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_o  <= {num_i[DW-2:0], 1'b0};
      quo_o  <= {quo_i[DW-2:0], ge};
      den_o  <= den_i;
      pass_o <= pass_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end
endmodule

[rtl/sjsc_sqrt_cell.sv]
// sjsc_sqrt_cell: one digit-by-digit square root cell, one root bit per cycle while en_i is high
// uses sjsc_pkg
module sjsc_sqrt_cell import sjsc_pkg::*; #(
  parameter int unsigned RTW = 34,
  parameter int unsigned PW  = 97
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*RTW-1:0] rad_i,
  input  logic [RTW+1:0]   rem_i,
  input  logic [RTW-1:0]   root_i,
  input  logic [PW-1:0]    pass_i,
  output logic             valid_o,
  output logic [2*RTW-1:0] rad_o,
  output logic [RTW+1:0]   rem_o,
  output logic [RTW-1:0]   root_o,
  output logic [PW-1:0]    pass_o
);
  logic [RTW+3:0] cand, sub;
  logic [RTW+4:0] diff;
  logic ge;

  // bring in two radicand bits, try 4*root+1
  always_comb begin
    cand = {rem_i, rad_i[2*RTW-1 -: 2]};
    sub  = {2'b00, root_i, 2'b01};
    diff = {1'b0, cand} - {1'b0, sub};
    ge   = ~diff[RTW+4];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RTW-3:0], 2'b00};
      rem_o  <= ge ? diff[RTW+1:0] : cand[RTW+1:0];
      root_o <= {root_i[RTW-2:0], ge};
      pass_o <= pass_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end
endmodule

[rtl/skeleton_joint_smooth_check.sv]
// skeleton_joint_smooth_check: top level of the joint smoothing check
// depends on sjsc_pkg, sjsc_if, sjsc_front, sjsc_div_cell, sjsc_sqrt_cell
//
// Usage: each transfer on in_i carries three points (previous start, previous
// end, current end). One result per item leaves on out_o: the distance of the
// previous start from the line through the current end and the previous end,
// the degenerate and adjust flags, and the midpoint when adjust is set.
// cfg_i writes the threshold; it is always ready. The threshold must be
// written only while idle; the block itself does not enforce this.
// Items pass six front stages, one divider cell per quotient bit, a subtract
// stage, one root cell per root bit and the output register. Throughput is
// one item per cycle unless the output stalls; the whole chain moves together.
// When the receiver stalls with a result held, the chain freezes and in_i
// ready drops; while the output register is empty items keep flowing.
// Reset clears all valid bits and sets the threshold to zero; no clearing pass.
module skeleton_joint_smooth_check import sjsc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sjsc_in_if.sink               in_i,
  sjsc_out_if.source            out_o,
  sjsc_cfg_if.sink              cfg_i
);
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned AW   = CW + 1;
  localparam int unsigned SUMW = 2 * AW + 2;
  localparam int unsigned RTW  = SUMW / 2;
  localparam int unsigned NUMW = 2 * SUMW;
  localparam int unsigned SDW  = 1 + Axes * CW;
  localparam int unsigned PW   = SUMW + SDW;

  logic en;
  logic [DistW-1:0] thr_q;
  logic out_v_q;

  // chain advances unless a held result is stalled
  assign en = ~out_v_q | out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  // front end
  logic f_v;
  logic [NUMW-1:0] f_num;
  logic [SUMW-1:0] f_den;
  logic [PW-1:0] f_pass;

  sjsc_front #(.CW(CW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .s_i     ({in_i.prev_start_z, in_i.prev_start_y, in_i.prev_start_x}),
    .p_i     ({in_i.prev_end_z, in_i.prev_end_y, in_i.prev_end_x}),
    .e_i     ({in_i.cur_end_z, in_i.cur_end_y, in_i.cur_end_x}),
    .valid_o (f_v),
    .num_o   (f_num),
    .den_o   (f_den),
    .pass_o  (f_pass)
  );

  // divider chain, one cell per quotient bit
  logic            dv   [SUMW+1];
  logic [SUMW-1:0] drem [SUMW+1];
  logic [SUMW-1:0] dnum [SUMW+1];
  logic [SUMW-1:0] dquo [SUMW+1];
  logic [SUMW-1:0] dden [SUMW+1];
  logic [PW-1:0]   dpas [SUMW+1];

  assign dv[0]   = f_v;
  assign drem[0] = f_num[NUMW-1:SUMW];
  assign dnum[0] = f_num[SUMW-1:0];
  assign dquo[0] = '0;
  assign dden[0] = f_den;
  assign dpas[0] = f_pass;

  for (genvar k = 0; k < SUMW; k++) begin : g_div
    sjsc_div_cell #(.DW(SUMW), .PW(PW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .rem_i   (drem[k]),
      .num_i   (dnum[k]),
      .quo_i   (dquo[k]),
      .den_i   (dden[k]),
      .pass_i  (dpas[k]),
      .valid_o (dv[k+1]),
      .rem_o   (drem[k+1]),
      .num_o   (dnum[k+1]),
      .quo_o   (dquo[k+1]),
      .den_o   (dden[k+1]),
      .pass_o  (dpas[k+1])
    );
  end

  // squared distance
  logic sub_v_q;
  logic [SUMW-1:0] d2_q;
  logic [SDW-1:0] side_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q   <= dpas[SUMW][PW-1:SDW] - dquo[SUMW];
      side_q <= dpas[SUMW][SDW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_v_q <= 1'b0;
    end else if (en) begin
      sub_v_q <= dv[SUMW];
    end
  end

  // root chain, one cell per root bit
  logic             rv    [RTW+1];
  logic [SUMW-1:0]  rrad  [RTW+1];
  logic [RTW+1:0]   rrem  [RTW+1];
  logic [RTW-1:0]   rroot [RTW+1];
  logic [SDW-1:0]   rpas  [RTW+1];

  assign rv[0]    = sub_v_q;
  assign rrad[0]  = d2_q;
  assign rrem[0]  = '0;
  assign rroot[0] = '0;
  assign rpas[0]  = side_q;

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    sjsc_sqrt_cell #(.RTW(RTW), .PW(SDW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rv[k]),
      .rad_i   (rrad[k]),
      .rem_i   (rrem[k]),
      .root_i  (rroot[k]),
      .pass_i  (rpas[k]),
      .valid_o (rv[k+1]),
      .rad_o   (rrad[k+1]),
      .rem_o   (rrem[k+1]),
      .root_o  (rroot[k+1]),
      .pass_o  (rpas[k+1])
    );
  end

  // saturation, threshold compare and midpoint select
  logic [RTW+DistW-1:0] rext;
  logic [DistW-1:0] dist_sat;
  logic deg, adj;
  logic [Axes-1:0][CW-1:0] mid;

  always_comb begin
    rext = {{DistW{1'b0}}, rroot[RTW]};
    dist_sat = (rext > (RTW+DistW)'(DistMax)) ? DistMax : rext[DistW-1:0];
    deg  = rpas[RTW][SDW-1];
    mid  = rpas[RTW][SDW-2:0];
    adj  = ~deg & (dist_sat > thr_q);
    if (deg) begin
      dist_sat = '0;
    end
  end

  // output register
  logic [DistW-1:0] dist_q;
  logic adj_q, deg_q;
  logic [Axes-1:0][CW-1:0] mid_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_sat;
      adj_q  <= adj;
      deg_q  <= deg;
      mid_q  <= adj ? mid : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= rv[RTW];
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.distance   = dist_q;
  assign out_o.adjust     = adj_q;
  assign out_o.degenerate = deg_q;
  assign out_o.mid_x      = mid_q[0];
  assign out_o.mid_y      = mid_q[1];
  assign out_o.mid_z      = mid_q[2];
endmodule
